### rtl/acps_pkg.sv
// acps_pkg: constants, types and steering codes for the coordinate parser.
// No dependencies; imported by every module of the block.
package acps_pkg;

	localparam int MAX_DIGITS = 3;
	localparam int SLOT_COUNT = 4;
	localparam int DIGIT_BIAS = 48;

	localparam int COUNT_W = 3;
	localparam int SLOT_W  = 3;

	localparam logic [7:0] BYTE_DOT   = 8'h2E;
	localparam logic [7:0] BYTE_COLON = 8'h3A;
	localparam logic [7:0] BYTE_ONE   = 8'h31;

	localparam logic [SLOT_W-1:0] NO_SLOT = 3'd7;

	localparam logic [1:0] STEER_STRAIGHT = 2'd0;
	localparam logic [1:0] STEER_POS      = 2'd1;
	localparam logic [1:0] STEER_NEG      = 2'd2;

	typedef logic [9:0]          thr_t;
	typedef logic signed [8:0]   digit_t;
	typedef logic signed [15:0]  coord_t;

	localparam thr_t TURN_THRESHOLD_RESET = 10'd7;

	typedef struct packed {
		coord_t slot0;
		coord_t slot1;
	} coord_pair_t;

endpackage

### rtl/acps_if.sv
// acps_if: valid/ready channels of the coordinate parser (byte in, result out,
// threshold write).
interface acps_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface acps_res_if;
	logic                valid;
	logic                ready;
	logic [1:0]          steer_code;
	logic signed [15:0]  coord_diff;
	modport source (output valid, output steer_code, output coord_diff, input ready);
	modport sink   (input valid, input steer_code, input coord_diff, output ready);
endinterface

interface acps_cfg_if;
	logic       valid;
	logic       ready;
	logic [9:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/ascii_coordinate_parser_steering_core.sv
// ascii_coordinate_parser_steering_core: top level of the coordinate parser.
// Uses acps_pkg, acps_if, acps_parser and acps_steer.
//
// Usage:
//   rx    - byte requests in (rx_byte), valid/ready.
//   steer - one result request per byte (steer_code, coord_diff), valid/ready.
//   cfg   - turn_threshold write, valid/ready; ready is always high. Write it
//           only while the block is idle.
// Path: an accepted byte passes the input register, then the result register,
//   before its result shows at the steer port.
// Throughput: one byte per cycle while the steer port takes results; the parse
//   state update and the diff and compare sit in the single stage between the two registers.
// Reset: parse state, coordinate slots and valid flags clear; threshold
//   returns to 7.
// Stall: while a result waits, the stage still holds one byte; with both
//   full, rx.ready drops until the result is taken.
module ascii_coordinate_parser_steering_core (
	input logic       clk,
	input logic       arst_n,
	acps_rx_if.sink   rx,
	acps_res_if.source steer,
	acps_cfg_if.sink  cfg
);
	import acps_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	thr_t        threshold_q;
	coord_pair_t coords_next;
	logic [1:0]  code_nxt;
	coord_t      diff_nxt;
	logic        res_valid_q;
	logic [1:0]  code_q;
	coord_t      diff_q;

	assign advance  = valid_s1 && (!res_valid_q || steer.ready);
	assign rx.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= TURN_THRESHOLD_RESET;
		end else if (cfg.valid) begin
			threshold_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid)
			byte_s1 <= rx.rx_byte;
	end

	acps_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_byte     (byte_s1),
		.coords_next (coords_next)
	);

	acps_steer u_steer (
		.coords     (coords_next),
		.threshold  (threshold_q),
		.steer_code (code_nxt),
		.coord_diff (diff_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (steer.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			code_q <= code_nxt;
			diff_q <= diff_nxt;
		end
	end

	assign steer.valid      = res_valid_q;
	assign steer.steer_code = code_q;
	assign steer.coord_diff = diff_q;

endmodule

### rtl/acps_parser.sv
// acps_parser: field parsing state and coordinate slots, one byte per step.
// Gives the slot 0 and slot 1 values as they stand after the byte. Uses acps_pkg.
module acps_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	output acps_pkg::coord_pair_t coords_next
);
	import acps_pkg::*;

	logic                field_open_q, field_open_nxt;
	logic [COUNT_W-1:0]  digit_count_q, digit_count_nxt;
	digit_t              digit_q   [MAX_DIGITS];
	digit_t              digit_nxt [MAX_DIGITS];
	logic [7:0]          prev_byte_q;
	logic [SLOT_W-1:0]   slot_sel_q, slot_sel_nxt;
	coord_t              coord_q   [SLOT_COUNT];
	coord_t              coord_nxt [SLOT_COUNT];
	coord_t              fold_val;
	digit_t              new_digit;

	assign new_digit = digit_t'({1'b0, rx_byte}) - digit_t'(DIGIT_BIAS);

	always_comb begin
		field_open_nxt  = field_open_q;
		digit_count_nxt = digit_count_q;
		slot_sel_nxt    = slot_sel_q;
		digit_nxt       = digit_q;
		coord_nxt       = coord_q;
		fold_val        = '0;

		if (field_open_q && rx_byte != BYTE_DOT) begin
			if (digit_count_q < COUNT_W'(MAX_DIGITS)) begin
				for (int k = 0; k < MAX_DIGITS; k++) begin
					if (digit_count_q == COUNT_W'(k))
						digit_nxt[k] = new_digit;
				end
				digit_count_nxt = digit_count_q + COUNT_W'(1);
			end else begin
				digit_count_nxt = COUNT_W'(MAX_DIGITS + 1);
			end
		end

		if (rx_byte == BYTE_COLON) begin
			field_open_nxt = 1'b1;
			if (prev_byte_q >= BYTE_ONE && prev_byte_q < BYTE_ONE + 8'(SLOT_COUNT))
				slot_sel_nxt = SLOT_W'(prev_byte_q - BYTE_ONE);
			else
				slot_sel_nxt = NO_SLOT;
		end

		if (rx_byte == BYTE_DOT) begin
			field_open_nxt = 1'b0;
			for (int k = 0; k < MAX_DIGITS; k++) begin
				if (COUNT_W'(k) < digit_count_q)
					fold_val = coord_t'(fold_val * coord_t'(10)) + coord_t'(digit_q[k]);
			end
			if (digit_count_q >= COUNT_W'(1) && digit_count_q <= COUNT_W'(MAX_DIGITS)) begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (slot_sel_q == SLOT_W'(i))
						coord_nxt[i] = fold_val;
				end
			end
			digit_count_nxt = '0;
			for (int k = 0; k < MAX_DIGITS; k++)
				digit_nxt[k] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_open_q  <= 1'b0;
			digit_count_q <= '0;
			prev_byte_q   <= '0;
			slot_sel_q    <= '0;
			for (int k = 0; k < MAX_DIGITS; k++)
				digit_q[k] <= '0;
			for (int i = 0; i < SLOT_COUNT; i++)
				coord_q[i] <= '0;
		end else if (step) begin
			field_open_q  <= field_open_nxt;
			digit_count_q <= digit_count_nxt;
			prev_byte_q   <= rx_byte;
			slot_sel_q    <= slot_sel_nxt;
			digit_q       <= digit_nxt;
			coord_q       <= coord_nxt;
		end
	end

	assign coords_next.slot0 = coord_nxt[0];
	assign coords_next.slot1 = coord_nxt[1];

endmodule

### rtl/acps_steer.sv
// acps_steer: slot 0 minus slot 1 and the threshold comparison.
// Uses acps_pkg.
module acps_steer (
	input  acps_pkg::coord_pair_t coords,
	input  acps_pkg::thr_t        threshold,
	output logic [1:0]            steer_code,
	output acps_pkg::coord_t      coord_diff
);
	import acps_pkg::*;

	logic signed [16:0] thr_pos;
	logic signed [16:0] diff_w;

	assign coord_diff = coords.slot0 - coords.slot1;
	assign diff_w     = 17'(coord_diff);
	assign thr_pos    = $signed({7'b0, threshold});

	always_comb begin
		priority if (diff_w >= thr_pos)
			steer_code = STEER_POS;
		else if (diff_w <= -thr_pos)
			steer_code = STEER_NEG;
		else
			steer_code = STEER_STRAIGHT;
	end

endmodule
